>>> rtl/core/bhs_pkg.sv
// Shared constants, codes and types of the bilinear height map sampler.
package bhs_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int HEIGHT_W       = 16;
    localparam int DEF_BANK_DEPTH = ((DEF_MAX_WIDTH + 1) / 2) * ((DEF_MAX_HEIGHT + 1) / 2);

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAP_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT_SCALE  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT_OFFSET = 2'd3;

    localparam logic [8:0]  RST_MAP_WIDTH     = 9'd256;
    localparam logic [8:0]  RST_MAP_HEIGHT    = 9'd256;
    localparam logic [15:0] RST_HEIGHT_SCALE  = 16'd256;
    localparam logic [23:0] RST_HEIGHT_OFFSET = 24'd0;

    // Luma weights, Q0.16
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Query sideband that travels alongside the bank reads
    typedef struct packed {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [1:0]  bank_tl;
        logic [1:0]  bank_tr;
        logic [1:0]  bank_bl;
        logic [1:0]  bank_br;
    } t_side;

endpackage

>>> rtl/core/bhs_ram.sv
// Generic single-port RAM with registered read data.
module bhs_ram #(
    parameter int WIDTH = bhs_pkg::HEIGHT_W,
    parameter int DEPTH = bhs_pkg::DEF_BANK_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bhs_front.sv
// Input stage: luma and coordinate products, neighbor clamping and bank request issue.
module bhs_front #(
    parameter int MAX_WIDTH   = bhs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bhs_pkg::DEF_MAX_HEIGHT,
    localparam int XW         = $clog2(MAX_WIDTH),
    localparam int YW         = $clog2(MAX_HEIGHT),
    localparam int HALF_W     = (MAX_WIDTH + 1) / 2,
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2,
    localparam int BANK_DEPTH = HALF_W * HALF_H,
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [7:0]                    i_entry_column,
    input  logic [7:0]                    i_entry_row,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [16:0]                   i_query_u,
    input  logic [16:0]                   i_query_v,
    input  logic [XW-1:0]                 i_width_m1,
    input  logic [YW-1:0]                 i_height_m1,
    input  logic                          i_s2_free,
    output logic                          o_bank_en [4],
    output logic                          o_bank_we,
    output logic [BAW-1:0]                o_bank_addr [4],
    output logic [bhs_pkg::HEIGHT_W-1:0]  o_bank_wdata,
    output logic                          o_side_valid,
    output bhs_pkg::t_side                o_side
);

    localparam int PUW = 17 + XW;
    localparam int PVW = 17 + YW;

    logic             r_v1;
    logic             r_cmd;
    logic [7:0]       r_col;
    logic [7:0]       r_row;
    logic [15:0]      r_luma;
    logic [PUW-1:0]   r_pu;
    logic [PVW-1:0]   r_pv;

    logic             w_accept;
    logic             w_move;
    logic [23:0]      w_luma_sum;
    logic [16:0]      w_uc;
    logic [16:0]      w_vc;
    logic [XW:0]      w_cell_x;
    logic [YW:0]      w_cell_y;
    logic [XW:0]      w_next_x;
    logic [YW:0]      w_next_y;
    logic [XW-1:0]    w_x1;
    logic [XW-1:0]    w_x2;
    logic [YW-1:0]    w_y1;
    logic [YW-1:0]    w_y2;
    logic             w_wr_ok;
    logic [1:0]       w_wr_bank;
    logic [BAW-1:0]   w_wr_addr;
    logic [BAW-1:0]   w_rd_addr [4];

    function automatic logic [BAW-1:0] f_addr(input logic [15:0] col, input logic [15:0] row);
        return BAW'(32'(row >> 1) * HALF_W + 32'(col >> 1));
    endfunction

    assign w_accept = i_valid && o_ready;
    assign w_move   = r_v1 && ((r_cmd == bhs_pkg::CMD_WRITE) || i_s2_free);
    assign o_ready  = !r_v1 || w_move;

    assign w_luma_sum = 24'(i_red) * 24'(bhs_pkg::LUMA_R)
                      + 24'(i_green) * 24'(bhs_pkg::LUMA_G)
                      + 24'(i_blue) * 24'(bhs_pkg::LUMA_B);

    assign w_uc = (i_query_u > bhs_pkg::ONE_Q16) ? bhs_pkg::ONE_Q16 : i_query_u;
    assign w_vc = (i_query_v > bhs_pkg::ONE_Q16) ? bhs_pkg::ONE_Q16 : i_query_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept || (r_v1 && !w_move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_col  <= i_entry_column;
            r_row  <= i_entry_row;
            r_luma <= w_luma_sum[23:8];
            r_pu   <= PUW'(w_uc) * PUW'(i_width_m1);
            r_pv   <= PVW'(w_vc) * PVW'(i_height_m1);
        end
    end

    // Integer cell and its right/lower neighbor, both clamped to the last column/row
    assign w_cell_x = r_pu[PUW-1:16];
    assign w_cell_y = r_pv[PVW-1:16];
    assign w_next_x = w_cell_x + (XW+1)'(1);
    assign w_next_y = w_cell_y + (YW+1)'(1);
    assign w_x1 = (w_cell_x > {1'b0, i_width_m1})  ? i_width_m1  : w_cell_x[XW-1:0];
    assign w_x2 = (w_next_x > {1'b0, i_width_m1})  ? i_width_m1  : w_next_x[XW-1:0];
    assign w_y1 = (w_cell_y > {1'b0, i_height_m1}) ? i_height_m1 : w_cell_y[YW-1:0];
    assign w_y2 = (w_next_y > {1'b0, i_height_m1}) ? i_height_m1 : w_next_y[YW-1:0];

    assign w_wr_ok   = (32'(r_col) < MAX_WIDTH) && (32'(r_row) < MAX_HEIGHT);
    assign w_wr_bank = {r_row[0], r_col[0]};
    assign w_wr_addr = f_addr(16'(r_col), 16'(r_row));

    // Bank {row parity, column parity}; x1/x2 and y1/y2 differ by at most one
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            w_rd_addr[b] = f_addr(16'((w_x1[0] == b[0]) ? w_x1 : w_x2),
                                  16'((w_y1[0] == b[1]) ? w_y1 : w_y2));
            if (r_cmd == bhs_pkg::CMD_WRITE) begin
                o_bank_en[b]   = w_move && w_wr_ok && (w_wr_bank == 2'(b));
                o_bank_addr[b] = w_wr_addr;
            end else begin
                o_bank_en[b]   = w_move;
                o_bank_addr[b] = w_rd_addr[b];
            end
        end
    end

    assign o_bank_we    = (r_cmd == bhs_pkg::CMD_WRITE);
    assign o_bank_wdata = r_luma;

    assign o_side_valid   = w_move && (r_cmd == bhs_pkg::CMD_QUERY);
    assign o_side.fx      = r_pu[15:0];
    assign o_side.fy      = r_pv[15:0];
    assign o_side.bank_tl = {w_y1[0], w_x1[0]};
    assign o_side.bank_tr = {w_y1[0], w_x2[0]};
    assign o_side.bank_bl = {w_y2[0], w_x1[0]};
    assign o_side.bank_br = {w_y2[0], w_x2[0]};

endmodule

>>> rtl/core/bhs_interp.sv
// Back end: corner select, x and y lerps, gain, offset and output register.
module bhs_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_side_valid,
    input  bhs_pkg::t_side                i_side,
    output logic                          o_s2_free,
    input  logic [bhs_pkg::HEIGHT_W-1:0]  i_bank_data [4],
    input  logic [15:0]                   i_height_scale,
    input  logic signed [23:0]            i_height_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [25:0]            o_sampled_height
);

    logic                  r_v2;
    logic                  r_v3;
    logic                  r_v4;
    logic                  r_v5;
    logic                  r_v6;
    bhs_pkg::t_side        r_side2;
    logic [15:0]           r_top;
    logic [15:0]           r_bot;
    logic [15:0]           r_fy3;
    logic [15:0]           r_mid;
    logic [23:0]           r_scaled;
    logic signed [25:0]    r_out;

    logic                  w_a2;
    logic                  w_a3;
    logic                  w_a4;
    logic                  w_a5;
    logic                  w_a6;
    logic [31:0]           w_prod;

    // (a*(1-f) + b*f) >> 16 rewritten as (a<<16 + (b-a)*f) >> 16
    function automatic logic [15:0] f_lerp(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] f);
        logic signed [16:0] d;
        logic signed [34:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        s = $signed({3'b000, a, 16'h0000}) + 35'(d * $signed({1'b0, f}));
        return s[31:16];
    endfunction

    assign w_a6 = r_v6 && i_ready;
    assign w_a5 = r_v5 && (!r_v6 || w_a6);
    assign w_a4 = r_v4 && (!r_v5 || w_a5);
    assign w_a3 = r_v3 && (!r_v4 || w_a4);
    assign w_a2 = r_v2 && (!r_v3 || w_a3);
    assign o_s2_free = !r_v2 || w_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v2 <= i_side_valid || (r_v2 && !w_a2);
            r_v3 <= w_a2 || (r_v3 && !w_a3);
            r_v4 <= w_a3 || (r_v4 && !w_a4);
            r_v5 <= w_a4 || (r_v5 && !w_a5);
            r_v6 <= w_a5 || (r_v6 && !w_a6);
        end
    end

    assign w_prod = 32'(r_mid) * 32'(i_height_scale);

    // Bank read data stays held in the RAM while this stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_side_valid) begin
            r_side2 <= i_side;
        end
        if (w_a2) begin
            r_top <= f_lerp(i_bank_data[r_side2.bank_tl], i_bank_data[r_side2.bank_tr],
                            r_side2.fx);
            r_bot <= f_lerp(i_bank_data[r_side2.bank_bl], i_bank_data[r_side2.bank_br],
                            r_side2.fx);
            r_fy3 <= r_side2.fy;
        end
        if (w_a3) begin
            r_mid <= f_lerp(r_top, r_bot, r_fy3);
        end
        if (w_a4) begin
            r_scaled <= w_prod[31:8];
        end
        if (w_a5) begin
            r_out <= $signed({2'b00, r_scaled})
                   + $signed({{2{i_height_offset[23]}}, i_height_offset});
        end
    end

    assign o_valid          = r_v6;
    assign o_sampled_height = r_out;

endmodule

>>> rtl/core/bilinear_heightmap_sampler_top.sv
// Top level of the bilinear height map sampler: configuration, bank RAMs and pipeline.
//
// Input channel (i_valid/o_ready): command 0 writes the luma of an RGB pixel to
// the map entry at (entry_column, entry_row); command 1 queries the bilinearly
// interpolated height at (query_u, query_v), Q0.16 over the map in use.
// Output channel (o_valid/i_ready): one sampled_height per query, in order;
// writes produce nothing.
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready): index 0 map
// width, 1 map height, 2 height scale (Q8.8), 3 height offset (Q15.8).
// Throughput is one item per cycle while the receiver does not stall. The map is
// split into four banks by row and column parity, so the four neighbors of a
// query are read in the same cycle. A query result passes through the input
// register, bank read, x lerps, y lerp, gain, then offset into the output register.
// A write passes the input register and then lands in its bank; a later query
// always sees it.
// Reset clears the pipeline and sets the registers to 256, 256, 256 and 0; the
// map contents are undefined until written.
// When the receiver stalls, the pipeline keeps absorbing items until every
// stage is full, then o_ready drops. Writes drain past stalled queries.
module bilinear_heightmap_sampler_top #(
    parameter int MAX_WIDTH  = bhs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bhs_pkg::DEF_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [7:0]         i_entry_column,
    input  logic [7:0]         i_entry_row,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [16:0]        i_query_u,
    input  logic [16:0]        i_query_v,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [25:0] o_sampled_height,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int BANK_DEPTH = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2);
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [8:0]                  r_map_width;
    logic [8:0]                  r_map_height;
    logic [15:0]                 r_height_scale;
    logic signed [23:0]          r_height_offset;

    logic [XW-1:0]               w_width_m1;
    logic [YW-1:0]               w_height_m1;
    logic                        w_s2_free;
    logic                        w_bank_en [4];
    logic                        w_bank_we;
    logic [BAW-1:0]              w_bank_addr [4];
    logic [bhs_pkg::HEIGHT_W-1:0] w_bank_wdata;
    logic [bhs_pkg::HEIGHT_W-1:0] w_bank_rdata [4];
    logic                        w_side_valid;
    bhs_pkg::t_side              w_side;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width     <= bhs_pkg::RST_MAP_WIDTH;
            r_map_height    <= bhs_pkg::RST_MAP_HEIGHT;
            r_height_scale  <= bhs_pkg::RST_HEIGHT_SCALE;
            r_height_offset <= bhs_pkg::RST_HEIGHT_OFFSET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bhs_pkg::CFG_MAP_WIDTH: begin
                    r_map_width <= i_cfg_data[8:0];
                end
                bhs_pkg::CFG_MAP_HEIGHT: begin
                    r_map_height <= i_cfg_data[8:0];
                end
                bhs_pkg::CFG_HEIGHT_SCALE: begin
                    r_height_scale <= i_cfg_data[15:0];
                end
                bhs_pkg::CFG_HEIGHT_OFFSET: begin
                    r_height_offset <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Map size in use minus one; zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_map_width == 9'd0) begin
            w_width_m1 = '0;
        end else if (32'(r_map_width) > MAX_WIDTH) begin
            w_width_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_width_m1 = XW'(32'(r_map_width) - 32'd1);
        end
        if (r_map_height == 9'd0) begin
            w_height_m1 = '0;
        end else if (32'(r_map_height) > MAX_HEIGHT) begin
            w_height_m1 = YW'(MAX_HEIGHT - 1);
        end else begin
            w_height_m1 = YW'(32'(r_map_height) - 32'd1);
        end
    end

    bhs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_entry_column (i_entry_column),
        .i_entry_row    (i_entry_row),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_query_u      (i_query_u),
        .i_query_v      (i_query_v),
        .i_width_m1     (w_width_m1),
        .i_height_m1    (w_height_m1),
        .i_s2_free      (w_s2_free),
        .o_bank_en      (w_bank_en),
        .o_bank_we      (w_bank_we),
        .o_bank_addr    (w_bank_addr),
        .o_bank_wdata   (w_bank_wdata),
        .o_side_valid   (w_side_valid),
        .o_side         (w_side)
    );

    for (genvar b = 0; b < 4; b++) begin : g_bank
        bhs_ram #(
            .WIDTH (bhs_pkg::HEIGHT_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (w_bank_en[b]),
            .i_we    (w_bank_we),
            .i_addr  (w_bank_addr[b]),
            .i_wdata (w_bank_wdata),
            .o_rdata (w_bank_rdata[b])
        );
    end

    bhs_interp u_interp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_side_valid     (w_side_valid),
        .i_side           (w_side),
        .o_s2_free        (w_s2_free),
        .i_bank_data      (w_bank_rdata),
        .i_height_scale   (r_height_scale),
        .i_height_offset  (r_height_offset),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sampled_height (o_sampled_height)
    );

endmodule

>>> test/bhs_height_checker.sv
`timescale 1ns / 100ps
// Height map sampler checker: tracks map and registers, predicts each sample, compares results.
module bhs_height_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_command,
    input  logic [7:0]         i_entry_column,
    input  logic [7:0]         i_entry_row,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [16:0]        i_query_u,
    input  logic [16:0]        i_query_v,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [25:0] i_sampled_height,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int MAP_W  = bhs_pkg::DEF_MAX_WIDTH;
    localparam int MAP_H  = bhs_pkg::DEF_MAX_HEIGHT;
    localparam int MAP_AW = $clog2(MAP_W * MAP_H);

    logic [15:0] luma_map [0:MAP_W*MAP_H-1];
    logic [8:0]  map_cols_reg;
    logic [8:0]  map_rows_reg;
    logic [15:0] gain_q8;
    logic [23:0] offset_q8;
    logic [25:0] expected_heights [$];
    logic [25:0] oldest_height;

    function automatic int clamp_dim(input logic [8:0] v, input int max_dim);
        if (v == 9'd0) return 1;
        if (int'(v) > max_dim) return max_dim;
        return int'(v);
    endfunction

    // packs {low cell, high cell, fraction}
    function automatic logic [47:0] coord_cells(input logic [16:0] coord, input int size);
        int prod;
        int whole;
        int lo;
        int hi;
        prod  = (coord > bhs_pkg::ONE_Q16 ? int'(bhs_pkg::ONE_Q16) : int'(coord)) * (size - 1);
        whole = prod >> 16;
        lo    = whole > size - 1 ? size - 1 : whole;
        hi    = whole + 1 > size - 1 ? size - 1 : whole + 1;
        return {lo[15:0], hi[15:0], prod[15:0]};
    endfunction

    function automatic logic [15:0] lerp_q16(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] f);
        logic [33:0] acc;
        acc = {18'd0, a} * ({17'd0, bhs_pkg::ONE_Q16} - {18'd0, f}) + {18'd0, b} * {18'd0, f};
        return acc[31:16];
    endfunction

    function automatic logic [15:0] pixel_luma(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        logic [31:0] acc;
        acc = {16'd0, bhs_pkg::LUMA_R} * {24'd0, r} + {16'd0, bhs_pkg::LUMA_G} * {24'd0, g}
            + {16'd0, bhs_pkg::LUMA_B} * {24'd0, b};
        return acc[23:8];
    endfunction

    function automatic logic [MAP_AW-1:0] map_index(input int col, input int row);
        return MAP_AW'(row * MAP_W + col);
    endfunction

    function automatic logic [25:0] sample_height(input logic [16:0] u, input logic [16:0] v);
        logic [47:0]        xs;
        logic [47:0]        ys;
        logic [15:0]        top;
        logic [15:0]        bot;
        logic [15:0]        mid;
        logic [31:0]        prod;
        logic signed [31:0] sum;
        xs  = coord_cells(u, clamp_dim(map_cols_reg, MAP_W));
        ys  = coord_cells(v, clamp_dim(map_rows_reg, MAP_H));
        top = lerp_q16(luma_map[map_index(int'(xs[47:32]), int'(ys[47:32]))],
                       luma_map[map_index(int'(xs[31:16]), int'(ys[47:32]))], xs[15:0]);
        bot = lerp_q16(luma_map[map_index(int'(xs[47:32]), int'(ys[31:16]))],
                       luma_map[map_index(int'(xs[31:16]), int'(ys[31:16]))], xs[15:0]);
        mid = lerp_q16(top, bot, ys[15:0]);
        prod = {16'd0, mid} * {16'd0, gain_q8};
        sum  = $signed({8'd0, prod[31:8]}) + $signed({{8{offset_q8[23]}}, offset_q8});
        return sum[25:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            map_cols_reg = bhs_pkg::RST_MAP_WIDTH;
            map_rows_reg = bhs_pkg::RST_MAP_HEIGHT;
            gain_q8      = bhs_pkg::RST_HEIGHT_SCALE;
            offset_q8    = bhs_pkg::RST_HEIGHT_OFFSET;
            expected_heights.delete();
            o_pending    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bhs_pkg::CFG_MAP_WIDTH:     map_cols_reg = i_cfg_data[8:0];
                    bhs_pkg::CFG_MAP_HEIGHT:    map_rows_reg = i_cfg_data[8:0];
                    bhs_pkg::CFG_HEIGHT_SCALE:  gain_q8      = i_cfg_data[15:0];
                    bhs_pkg::CFG_HEIGHT_OFFSET: offset_q8    = i_cfg_data;
                    default: ;
                endcase
            end
            // compare first so a result is never matched against a query of this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_heights.size() == 0) begin
                    $display("%0t: unexpected sampled_height %0d, nothing expected",
                             $time, i_sampled_height);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    oldest_height = expected_heights.pop_front();
                    if (i_sampled_height !== oldest_height) begin
                        $display("%0t: sampled_height expected %0d, got %0d", $time,
                                 $signed(oldest_height), i_sampled_height);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == bhs_pkg::CMD_WRITE) begin
                    if (int'(i_entry_column) < MAP_W && int'(i_entry_row) < MAP_H) begin
                        luma_map[map_index(int'(i_entry_column), int'(i_entry_row))] =
                            pixel_luma(i_red, i_green, i_blue);
                    end
                end else begin
                    expected_heights.push_back(sample_height(i_query_u, i_query_v));
                end
            end
            o_pending = expected_heights.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the height map sampler: clock, reset, stimulus, handshake idling, verdict.
module tb;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAP_W        = bhs_pkg::DEF_MAX_WIDTH;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               i_command        = bhs_pkg::CMD_WRITE;
    logic [7:0]         i_entry_column   = 8'd0;
    logic [7:0]         i_entry_row      = 8'd0;
    logic [7:0]         i_red            = 8'd0;
    logic [7:0]         i_green          = 8'd0;
    logic [7:0]         i_blue           = 8'd0;
    logic [16:0]        i_query_u        = 17'd0;
    logic [16:0]        i_query_v        = 17'd0;
    logic               i_ready          = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic [1:0]         i_cfg_index      = bhs_pkg::CFG_MAP_WIDTH;
    logic [23:0]        i_cfg_data       = 24'd0;
    logic               o_ready;
    logic               o_valid;
    logic               o_cfg_ready;
    logic signed [25:0] o_sampled_height;

    int fail_count;
    int pending;
    bit gaps_on  = 1'b0;
    int map_cols = 256;
    int map_rows = 256;
    bit cell_written [0:65535];

    bilinear_heightmap_sampler_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_entry_column   (i_entry_column),
        .i_entry_row      (i_entry_row),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_query_u        (i_query_u),
        .i_query_v        (i_query_v),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sampled_height (o_sampled_height),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    bhs_height_checker height_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_command        (i_command),
        .i_entry_column   (i_entry_column),
        .i_entry_row      (i_entry_row),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_query_u        (i_query_u),
        .i_query_v        (i_query_v),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_sampled_height (o_sampled_height),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_cycles();
        int roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int dim_in_use(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (int'(v) > MAP_W) return MAP_W;
        return int'(v);
    endfunction

    function automatic logic [16:0] pick_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 17'd0;
        if (roll < 10) return bhs_pkg::ONE_Q16;
        if (roll < 14) return 17'd65535;
        if (roll < 20) return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic [15:0] cell_index(input int col, input int row);
        return 16'(row * MAP_W + col);
    endfunction

    // map size register value: mostly small maps, with junk above bit 8
    function automatic logic [23:0] random_dim();
        int          roll;
        logic [31:0] junk;
        logic [8:0]  dim;
        roll = $urandom_range(0, 99);
        junk = $urandom;
        if (roll < 70)      dim = 9'($urandom_range(1, 16));
        else if (roll < 90) dim = 9'($urandom_range(17, 256));
        else if (roll < 95) dim = 9'd0;
        else                dim = 9'($urandom_range(257, 511));
        return {junk[14:0], dim};
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] col, input logic [7:0] row,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [16:0] u, input logic [16:0] v);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_entry_column <= col;
        i_entry_row    <= row;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        i_query_u      <= u;
        i_query_v      <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_entry(input int col, input int row, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        send_item(bhs_pkg::CMD_WRITE, col[7:0], row[7:0], r, g, b,
                  17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
        cell_written[cell_index(col, row)] = 1'b1;
    endtask

    task automatic write_random_entry(input int col, input int row);
        write_entry(col, row, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    endtask

    task automatic coord_span(input logic [16:0] c, input int size, output int lo,
                              output int hi);
        int prod;
        prod = (c > bhs_pkg::ONE_Q16 ? int'(bhs_pkg::ONE_Q16) : int'(c)) * (size - 1);
        lo = prod >> 16;
        hi = lo + 1;
        if (lo > size - 1) lo = size - 1;
        if (hi > size - 1) hi = size - 1;
    endtask

    // fills any unwritten neighbor first so the query never reads an undefined entry
    task automatic query_height(input logic [16:0] u, input logic [16:0] v);
        int x_lo;
        int x_hi;
        int y_lo;
        int y_hi;
        coord_span(u, map_cols, x_lo, x_hi);
        coord_span(v, map_rows, y_lo, y_hi);
        if (!cell_written[cell_index(x_lo, y_lo)]) write_random_entry(x_lo, y_lo);
        if (!cell_written[cell_index(x_hi, y_lo)]) write_random_entry(x_hi, y_lo);
        if (!cell_written[cell_index(x_lo, y_hi)]) write_random_entry(x_lo, y_hi);
        if (!cell_written[cell_index(x_hi, y_hi)]) write_random_entry(x_hi, y_hi);
        send_item(bhs_pkg::CMD_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), u, v);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // writes have no result; let the last one settle too
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [23:0] cols, input logic [23:0] rows,
                             input logic [23:0] gain, input logic [23:0] offset);
        wait_for_results();
        write_reg(bhs_pkg::CFG_MAP_WIDTH, cols);
        write_reg(bhs_pkg::CFG_MAP_HEIGHT, rows);
        write_reg(bhs_pkg::CFG_HEIGHT_SCALE, gain);
        write_reg(bhs_pkg::CFG_HEIGHT_OFFSET, offset);
        map_cols = dim_in_use(cols[8:0]);
        map_rows = dim_in_use(rows[8:0]);
        gaps_on  = ($urandom_range(0, 3) != 0);
    endtask

    task automatic random_items(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                wait_for_results();
            end else if (roll < 57) begin
                query_height(pick_coord(), pick_coord());
            end else if (roll < 87) begin
                write_random_entry($urandom_range(0, map_cols - 1),
                                   $urandom_range(0, map_rows - 1));
            end else begin
                write_random_entry($urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
    endtask

    // result side back-pressure
    initial begin
        int stall;
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            stall = idle_cycles();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAIL bilinear_heightmap_sampler_top");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners and one inner entry with extreme pixels, then queries at and near edges and beyond one
        write_entry(0, 0, 8'd0, 8'd0, 8'd0);
        write_entry(255, 0, 8'd255, 8'd255, 8'd255);
        write_entry(0, 255, 8'd255, 8'd0, 8'd0);
        write_entry(255, 255, 8'd0, 8'd255, 8'd0);
        write_entry(128, 127, 8'd0, 8'd0, 8'd255);
        query_height(17'd0, 17'd0);
        query_height(bhs_pkg::ONE_Q16, bhs_pkg::ONE_Q16);
        query_height(bhs_pkg::ONE_Q16, 17'd0);
        query_height(17'd0, bhs_pkg::ONE_Q16);
        query_height(17'h1FFFF, 17'h1FFFF);
        query_height(17'd65535, 17'd65535);
        query_height(17'd32768, 17'd100000);
        query_height(17'd1, 17'd70000);

        // neighbor fills roughly double the item count on large maps
        configure(24'd1, 24'd1, 24'h00FFFF, 24'h7FFFFF);
        random_items(20);
        configure(24'd0, 24'd0, 24'd0, 24'h800000);
        random_items(20);
        configure(24'hFFFFFF, 24'h000101, 24'h00FFFF, 24'h800000);
        random_items(50);
        configure(24'd256, 24'd256, 24'h00FFFF, 24'h7FFFFF);
        random_items(50);
        configure(24'd2, 24'd2, 24'($urandom_range(0, 65535)),
                  24'($urandom_range(0, 24'hFFFFFF)));
        random_items(30);
        repeat (6) begin
            configure(random_dim(), random_dim(), 24'($urandom_range(0, 65535)),
                      24'($urandom_range(0, 24'hFFFFFF)));
            random_items(75);
        end

        wait_for_results();
        if (fail_count == 0) begin
            $display("PASS bilinear_heightmap_sampler_top");
        end else begin
            $display("FAIL bilinear_heightmap_sampler_top");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bhs_pkg.sv
rtl/core/bhs_ram.sv
rtl/core/bhs_front.sv
rtl/core/bhs_interp.sv
rtl/core/bilinear_heightmap_sampler_top.sv
test/bhs_height_checker.sv
test/tb.sv
